@@ hdl/serial_port_router_with_timeouts_defines.svh @@
// Assertion macros shared by the router's checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef SERIAL_PORT_ROUTER_WITH_TIMEOUTS_DEFINES_SVH
`define SERIAL_PORT_ROUTER_WITH_TIMEOUTS_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SPR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("router check failed");

// Next-cycle implication, disabled in reset.
`define SPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("router check failed");

`endif

@@ hdl/spr_pkg.sv @@
// Types and codes of the serial port router.
// No dependencies; used by the interfaces, the ring, the top level and the checker.
package spr_pkg;

	localparam int unsigned TMR_W   = 12;
	localparam int unsigned PWM_W   = 9;
	localparam int unsigned DUTY_W  = 11;
	localparam int unsigned CFG_IW  = 3;
	localparam int unsigned CFG_DW  = 12;

	// Input kinds
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_HOST  = 3'd1;
	localparam logic [2:0] KIND_BOX   = 3'd2;
	localparam logic [2:0] KIND_CARD  = 3'd3;
	localparam logic [2:0] KIND_TXRDY = 3'd4;

	// Result ports
	localparam logic [2:0] PORT_NONE  = 3'd0;
	localparam logic [2:0] PORT_HOST  = 3'd1;
	localparam logic [2:0] PORT_BOX   = 3'd2;
	localparam logic [2:0] PORT_CARD  = 3'd3;
	localparam logic [2:0] PORT_RESET = 3'd4;

	// Host destinations
	localparam logic [7:0] DEST_CTRL  = 8'd0;
	localparam logic [7:0] DEST_RING  = 8'd1;
	localparam logic [7:0] DEST_CARD  = 8'd2;
	localparam logic [7:0] DEST_LIGHT = 8'd4;

	// Control channel commands
	localparam logic [7:0] CTRL_ECHO  = 8'd0;
	localparam logic [7:0] CTRL_RESET = 8'd1;

	// Source prefixes toward the host
	localparam logic [7:0] SRC_BOX  = 8'd1;
	localparam logic [7:0] SRC_CARD = 8'd2;

	localparam logic [7:0] BOX_DATA_LIMIT = 8'h80;

	// Register indexes
	localparam logic [CFG_IW-1:0] CFG_ROUTE_TIMEOUT = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_HOLD_LONG     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_HOLD_SHORT    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_PWM_TOP       = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_RAMP_STEP     = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_LIGHT_SCALE   = 3'd5;

	// Register reset values
	localparam logic [TMR_W-1:0] RST_ROUTE_TIMEOUT = 12'd2500;
	localparam logic [TMR_W-1:0] RST_HOLD_LONG     = 12'd2500;
	localparam logic [TMR_W-1:0] RST_HOLD_SHORT    = 12'd250;
	localparam logic [PWM_W-1:0] RST_PWM_TOP       = 9'd499;
	localparam logic [4:0]       RST_RAMP_STEP     = 5'd5;
	localparam logic [2:0]       RST_LIGHT_SCALE   = 3'd5;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} spr_ring_ctl_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [7:0] rdata;
	} spr_ring_sts_t;

endpackage

@@ hdl/spr_ifs.sv @@
// Valid/ready channel interfaces of the router: input items, results, register writes.
// Depends on spr_pkg for field widths.
interface spr_item_if import spr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data;
	modport source (output valid, kind, data, input ready);
	modport sink (input valid, kind, data, output ready);
endinterface

interface spr_result_if import spr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [2:0] port;
	logic [7:0] byte_out;
	logic       light_on;
	logic       bus_drive;
	logic       last;
	modport source (output valid, port, byte_out, light_on, bus_drive, last, input ready);
	modport sink (input valid, port, byte_out, light_on, bus_drive, last, output ready);
endinterface

interface spr_cfg_if import spr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

@@ hdl/spr_ring.sv @@
// Transmit ring toward the box driver: byte memory with registered read.
// Depends on spr_pkg for the control and status structs.
module spr_ring import spr_pkg::*; #(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spr_ring_ctl_t ctl,
	output spr_ring_sts_t sts
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

	logic [7:0]    ring_mem_q [RING_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] rd_ptr_q, wr_ptr_q;
	logic [AW-1:0] rd_nxt, wr_nxt;

	assign rd_nxt = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign wr_nxt = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;

	assign sts.full  = (wr_nxt == rd_ptr_q);
	assign sts.empty = (wr_ptr_q == rd_ptr_q);
	assign sts.rdata = rdata_q;

	// A pop never reads the entry being pushed: the ring is nonempty then.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ring_mem_q[wr_ptr_q] <= ctl.wdata;
		end
		if (ctl.pop) begin
			rdata_q <= ring_mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_nxt;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_nxt;
			end
		end
	end

endmodule

@@ hdl/serial_port_router_with_timeouts.sv @@
// Top level of the serial port router with timeouts.
// Depends on spr_pkg, the channel interfaces in spr_ifs.sv and spr_ring.
//
// Channels: item (kind, data) in, result (port, byte_out, light_on, bus_drive,
// last) out, cfg (index, wdata) register writes; all valid/ready, a beat moves
// at a clock edge with valid and ready high. cfg is always ready.
// Every item gives one result, or two when a device byte needs a source prefix;
// the last one carries last = 1.
// Latency: the first result of an item is valid the cycle after its beat.
// Throughput: one item per cycle while result ready is high and each gives one
// result; a prefix beat stalls items; set by the single result register.
// Ring bytes come from a memory with a registered read, issued in the
// cycle the transmitter-ready item is taken.
// Reset: registers return to their defaults, timers, PWM and ring pointers to
// zero; ring memory contents are left as they are and are never read unwritten.
// Stall: a result held by a low result ready keeps its payload; item ready
// stays low until the last result of the pending item is taken.
module serial_port_router_with_timeouts import spr_pkg::*; #(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	spr_item_if.sink        item,
	spr_result_if.source    result,
	spr_cfg_if.sink         cfg
);

	// Registers
	logic [TMR_W-1:0] route_to_q, hold_long_q, hold_short_q;
	logic [PWM_W-1:0] pwm_top_q;
	logic [4:0]       ramp_step_q;
	logic [2:0]       light_scale_q;

	// Router state
	logic [7:0]        dest_q;
	logic [TMR_W-1:0]  sel_tmr_q, src_tmr_q, drv_tmr_q;
	logic              drv_flag_q;
	logic [PWM_W-1:0]  pwm_cnt_q;
	logic [DUTY_W-1:0] duty_now_q, duty_tgt_q;

	logic [7:0]        dest_d;
	logic [TMR_W-1:0]  sel_tmr_d, src_tmr_d, drv_tmr_d;
	logic              drv_flag_d;
	logic [PWM_W-1:0]  pwm_cnt_d;
	logic [DUTY_W-1:0] duty_now_d, duty_tgt_d;

	// Result register
	logic       res_vld_s1, two_s1, mem_s1, light_s1, drive_s1;
	logic [2:0] port_s1;
	logic [7:0] byte_s1, pfx_s1;

	logic       two_d, mem_d;
	logic [2:0] port_d;
	logic [7:0] byte_d, pfx_d;

	logic [PWM_W:0]    pwm_inc;
	logic [DUTY_W:0]   duty_up;
	logic [DUTY_W-1:0] duty_diff;

	spr_ring_ctl_t ring_ctl;
	spr_ring_sts_t ring_sts;

	logic acc, res_take;

	assign acc      = item.valid && item.ready;
	assign res_take = result.valid && result.ready;

	assign item.ready = !res_vld_s1 || (result.ready && !two_s1);
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_to_q    <= RST_ROUTE_TIMEOUT;
			hold_long_q   <= RST_HOLD_LONG;
			hold_short_q  <= RST_HOLD_SHORT;
			pwm_top_q     <= RST_PWM_TOP;
			ramp_step_q   <= RST_RAMP_STEP;
			light_scale_q <= RST_LIGHT_SCALE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ROUTE_TIMEOUT: route_to_q    <= cfg.wdata;
				CFG_HOLD_LONG:     hold_long_q   <= cfg.wdata;
				CFG_HOLD_SHORT:    hold_short_q  <= cfg.wdata;
				CFG_PWM_TOP:       pwm_top_q     <= cfg.wdata[PWM_W-1:0];
				CFG_RAMP_STEP:     ramp_step_q   <= cfg.wdata[4:0];
				CFG_LIGHT_SCALE:   light_scale_q <= cfg.wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	assign pwm_inc   = {1'b0, pwm_cnt_q} + 1'b1;
	assign duty_up   = {1'b0, duty_now_q} + (DUTY_W + 1)'(ramp_step_q);
	assign duty_diff = duty_now_q - duty_tgt_q;

	always_comb begin
		dest_d     = dest_q;
		sel_tmr_d  = sel_tmr_q;
		src_tmr_d  = src_tmr_q;
		drv_tmr_d  = drv_tmr_q;
		drv_flag_d = drv_flag_q;
		pwm_cnt_d  = pwm_cnt_q;
		duty_now_d = duty_now_q;
		duty_tgt_d = duty_tgt_q;
		two_d      = 1'b0;
		mem_d      = 1'b0;
		port_d     = PORT_NONE;
		byte_d     = 8'd0;
		pfx_d      = SRC_BOX;
		ring_ctl   = '{push: 1'b0, pop: 1'b0, wdata: item.data};

		case (item.kind)
			KIND_TICK: begin
				if (src_tmr_q != '0) src_tmr_d = src_tmr_q - 1'b1;
				if (sel_tmr_q != '0) sel_tmr_d = sel_tmr_q - 1'b1;
				if (drv_tmr_q != '0) drv_tmr_d = drv_tmr_q - 1'b1;
				else drv_flag_d = 1'b0;
				if (pwm_inc > {1'b0, pwm_top_q}) begin
					pwm_cnt_d = '0;
					// Step the duty toward its target without overshoot.
					if (duty_now_q < duty_tgt_q) begin
						if (duty_up > {1'b0, duty_tgt_q}) duty_now_d = duty_tgt_q;
						else duty_now_d = duty_up[DUTY_W-1:0];
					end else if (duty_now_q > duty_tgt_q) begin
						if (duty_diff <= DUTY_W'(ramp_step_q)) duty_now_d = duty_tgt_q;
						else duty_now_d = duty_now_q - DUTY_W'(ramp_step_q);
					end
				end else begin
					pwm_cnt_d = pwm_inc[PWM_W-1:0];
				end
			end
			KIND_HOST: begin
				if (sel_tmr_q == '0) begin
					sel_tmr_d = route_to_q;
					dest_d    = item.data;
				end else begin
					case (dest_q)
						DEST_CTRL: begin
							if (item.data == CTRL_ECHO) begin
								port_d = PORT_HOST;
							end else if (item.data == CTRL_RESET) begin
								port_d = PORT_RESET;
							end
						end
						DEST_RING: begin
							drv_flag_d    = 1'b1;
							drv_tmr_d     = hold_long_q;
							ring_ctl.push = !ring_sts.full;
						end
						DEST_CARD: begin
							port_d = PORT_CARD;
							byte_d = item.data;
						end
						DEST_LIGHT: begin
							duty_tgt_d = DUTY_W'(item.data) * DUTY_W'(light_scale_q);
						end
						default: begin
						end
					endcase
				end
			end
			KIND_BOX, KIND_CARD: begin
				// Drop high box bytes and box bytes heard while the drive hold timer runs.
				if (item.kind == KIND_CARD ||
				    (item.data < BOX_DATA_LIMIT && drv_tmr_q == '0)) begin
					port_d = PORT_HOST;
					byte_d = item.data;
					pfx_d  = (item.kind == KIND_CARD) ? SRC_CARD : SRC_BOX;
					if (src_tmr_q == '0) begin
						src_tmr_d = route_to_q;
						two_d     = 1'b1;
					end
				end
			end
			KIND_TXRDY: begin
				if (!ring_sts.empty) begin
					ring_ctl.pop = 1'b1;
					port_d       = PORT_BOX;
					mem_d        = 1'b1;
					drv_tmr_d    = hold_short_q;
				end
			end
			default: begin
			end
		endcase

		if (!acc) begin
			ring_ctl.push = 1'b0;
			ring_ctl.pop  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q     <= '0;
			sel_tmr_q  <= '0;
			src_tmr_q  <= '0;
			drv_tmr_q  <= '0;
			drv_flag_q <= 1'b0;
			pwm_cnt_q  <= '0;
			duty_now_q <= '0;
			duty_tgt_q <= '0;
			res_vld_s1 <= 1'b0;
			two_s1     <= 1'b0;
		end else begin
			if (acc) begin
				dest_q     <= dest_d;
				sel_tmr_q  <= sel_tmr_d;
				src_tmr_q  <= src_tmr_d;
				drv_tmr_q  <= drv_tmr_d;
				drv_flag_q <= drv_flag_d;
				pwm_cnt_q  <= pwm_cnt_d;
				duty_now_q <= duty_now_d;
				duty_tgt_q <= duty_tgt_d;
				res_vld_s1 <= 1'b1;
				two_s1     <= two_d;
			end else if (res_take) begin
				// Drop the prefix beat first, then the whole result.
				if (two_s1) two_s1 <= 1'b0;
				else res_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			port_s1  <= port_d;
			byte_s1  <= byte_d;
			pfx_s1   <= pfx_d;
			mem_s1   <= mem_d;
			light_s1 <= (DUTY_W'(pwm_cnt_d) < duty_now_d);
			drive_s1 <= drv_flag_d;
		end
	end

	assign result.valid     = res_vld_s1;
	assign result.port      = two_s1 ? PORT_HOST : port_s1;
	assign result.byte_out  = two_s1 ? pfx_s1 : (mem_s1 ? ring_sts.rdata : byte_s1);
	assign result.light_on  = light_s1;
	assign result.bus_drive = drive_s1;
	assign result.last      = !two_s1;

	spr_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ring_ctl),
		.sts   (ring_sts)
	);

endmodule

@@ hdl/spr_checker.sv @@
// Port-level checks of the router's result channel, bound to the top level.
// Depends on spr_pkg and the macros in serial_port_router_with_timeouts_defines.svh.
`include "serial_port_router_with_timeouts_defines.svh"

module spr_checker import spr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_port,
	input logic [7:0] res_byte,
	input logic       res_last
);

	`SPR_ASSERT_NOW(a_empty_byte, res_valid && (res_port == PORT_NONE || res_port == PORT_RESET), res_byte == 8'd0)
	`SPR_ASSERT_NOW(a_prefix_only, res_valid && !res_last, res_port == PORT_HOST && (res_byte == SRC_BOX || res_byte == SRC_CARD))
	`SPR_ASSERT_NEXT(a_prefix_follow, res_valid && res_ready && !res_last, res_valid && res_last)
	`SPR_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(res_byte) && $stable(res_port))

endmodule

bind serial_port_router_with_timeouts spr_checker u_spr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_port (result.port),
	.res_byte (result.byte_out),
	.res_last (result.last)
);

@@ test/serial_port_router_with_timeouts_test.sv @@
// Self-checking testbench for the serial port router with timeouts.
// Drives items and register writes over the spr_ifs.sv channel interfaces and checks every
// result beat against an in-bench model of the router; needs only the RTL.
module serial_port_router_with_timeouts_test;
	import spr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_SIZE = 256;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [2:0] port;
		logic [7:0] byte_out;
		logic       light_on;
		logic       bus_drive;
		logic       last;
	} route_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	spr_item_if   item_ch ();
	spr_result_if res_ch ();
	spr_cfg_if    cfg_ch ();

	serial_port_router_with_timeouts #(
		.RING_DEPTH(RING_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Router copy: registers
	logic [TMR_W-1:0]  cfg_route_to;
	logic [TMR_W-1:0]  cfg_hold_long;
	logic [TMR_W-1:0]  cfg_hold_short;
	logic [PWM_W-1:0]  cfg_pwm_top;
	logic [4:0]        cfg_ramp;
	logic [2:0]        cfg_scale;

	// Router copy: state
	logic [7:0]        dest_sel;
	logic [TMR_W-1:0]  sel_ticks;
	logic [TMR_W-1:0]  src_ticks;
	logic [TMR_W-1:0]  hold_ticks;
	logic              drive_on;
	logic [7:0]        ring_mem [RING_SIZE];
	int                rd_ptr;
	int                wr_ptr;
	logic [PWM_W-1:0]  pwm_cnt;
	logic [DUTY_W-1:0] duty_cur;
	logic [DUTY_W-1:0] duty_goal;

	route_beat_t routed_beats[$];

	int  mismatches = 0;
	int  items_sent = 0;
	int  beats_seen = 0;
	int  settings_used = 0;
	bit  quiet_mode = 1'b0;
	bit  hold_req = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the router copy by one item and queue the beats it sends.
	function automatic void route_item(input logic [2:0] kind, input logic [7:0] din);
		logic [2:0]  port_v [2];
		logic [7:0]  byte_v [2];
		route_beat_t b;
		int          n;
		int          c;
		int          nxt;
		n = 0;
		case (kind)
		KIND_TICK: begin
			if (src_ticks != 0)
				src_ticks = src_ticks - 1'b1;
			if (sel_ticks != 0)
				sel_ticks = sel_ticks - 1'b1;
			if (hold_ticks != 0)
				hold_ticks = hold_ticks - 1'b1;
			else
				drive_on = 1'b0;
			c = int'(pwm_cnt) + 1;
			if (c > int'(cfg_pwm_top)) begin
				c = 0;
				// step the duty toward its target, never past it
				if (duty_cur < duty_goal) begin
					if (int'(duty_cur) + int'(cfg_ramp) > int'(duty_goal))
						duty_cur = duty_goal;
					else
						duty_cur = duty_cur + cfg_ramp;
				end else if (duty_cur > duty_goal) begin
					if (int'(duty_cur) - int'(duty_goal) <= int'(cfg_ramp))
						duty_cur = duty_goal;
					else
						duty_cur = duty_cur - cfg_ramp;
				end
			end
			pwm_cnt = c[PWM_W-1:0];
		end
		KIND_HOST: begin
			if (sel_ticks == 0) begin
				sel_ticks = cfg_route_to;
				dest_sel = din;
			end else begin
				case (dest_sel)
				DEST_CTRL: begin
					if (din == CTRL_ECHO) begin
						port_v[0] = PORT_HOST;
						byte_v[0] = 8'h00;
						n = 1;
					end else if (din == CTRL_RESET) begin
						port_v[0] = PORT_RESET;
						byte_v[0] = 8'h00;
						n = 1;
					end
				end
				DEST_RING: begin
					// one slot stays free; a byte into a full ring is lost
					nxt = (wr_ptr == RING_SIZE - 1) ? 0 : wr_ptr + 1;
					drive_on = 1'b1;
					if (nxt != rd_ptr) begin
						ring_mem[wr_ptr] = din;
						wr_ptr = nxt;
					end
					hold_ticks = cfg_hold_long;
				end
				DEST_CARD: begin
					port_v[0] = PORT_CARD;
					byte_v[0] = din;
					n = 1;
				end
				DEST_LIGHT: duty_goal = din * cfg_scale;
				default: ;
				endcase
			end
		end
		KIND_BOX, KIND_CARD: begin
			if (kind == KIND_CARD || (din < BOX_DATA_LIMIT && hold_ticks == 0)) begin
				if (src_ticks == 0) begin
					src_ticks = cfg_route_to;
					port_v[n] = PORT_HOST;
					byte_v[n] = (kind == KIND_CARD) ? SRC_CARD : SRC_BOX;
					n++;
				end
				port_v[n] = PORT_HOST;
				byte_v[n] = din;
				n++;
			end
		end
		KIND_TXRDY: begin
			if (rd_ptr != wr_ptr) begin
				port_v[0] = PORT_BOX;
				byte_v[0] = ring_mem[rd_ptr];
				rd_ptr = (rd_ptr == RING_SIZE - 1) ? 0 : rd_ptr + 1;
				hold_ticks = cfg_hold_short;
				n = 1;
			end
		end
		default: ;
		endcase
		if (n == 0) begin
			port_v[0] = PORT_NONE;
			byte_v[0] = 8'h00;
			n = 1;
		end
		for (int k = 0; k < n; k++) begin
			b.port      = port_v[k];
			b.byte_out  = byte_v[k];
			b.light_on  = (pwm_cnt < duty_cur);
			b.bus_drive = drive_on;
			b.last      = (k == n - 1);
			routed_beats.push_back(b);
		end
	endfunction

	// Call at a rising edge; returns at the edge that takes the beat.
	task automatic send_item(input logic [2:0] kind, input logic [7:0] din);
		int gap;
		gap = quiet_mode ? 0 : pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind  <= kind;
		item_ch.data  <= din;
		do @(posedge clk); while (!item_ch.ready);
		route_item(kind, din);
		items_sent++;
	endtask

	// Hold the sender until every queued beat has come back.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (routed_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		case (idx)
		CFG_ROUTE_TIMEOUT: cfg_route_to = val;
		CFG_HOLD_LONG:     cfg_hold_long = val;
		CFG_HOLD_SHORT:    cfg_hold_short = val;
		CFG_PWM_TOP:       cfg_pwm_top = val[PWM_W-1:0];
		CFG_RAMP_STEP:     cfg_ramp = val[4:0];
		CFG_LIGHT_SCALE:   cfg_scale = val[2:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(input int route, input int hold_l, input int hold_s,
			input int top, input int ramp, input int scale);
		settle();
		write_reg(CFG_ROUTE_TIMEOUT, CFG_DW'(route));
		write_reg(CFG_HOLD_LONG, CFG_DW'(hold_l));
		write_reg(CFG_HOLD_SHORT, CFG_DW'(hold_s));
		write_reg(CFG_PWM_TOP, CFG_DW'(top));
		write_reg(CFG_RAMP_STEP, CFG_DW'(ramp));
		write_reg(CFG_LIGHT_SCALE, CFG_DW'(scale));
		settings_used++;
	endtask

	task automatic send_random_item();
		int         pick;
		logic [2:0] kind;
		logic [7:0] din;
		pick = $urandom_range(0, 99);
		din = 8'($urandom);
		if (pick < 30) begin
			kind = KIND_TICK;
		end else if (pick < 65) begin
			kind = KIND_HOST;
			// mostly pick a real destination when a selection is due
			if (sel_ticks == 0 && $urandom_range(0, 6) != 0) begin
				case ($urandom_range(0, 3))
				0: din = DEST_CTRL;
				1: din = DEST_RING;
				2: din = DEST_CARD;
				default: din = DEST_LIGHT;
				endcase
			end else if (sel_ticks != 0 && dest_sel == DEST_CTRL &&
					$urandom_range(0, 2) != 0) begin
				din = $urandom_range(0, 1) ? CTRL_RESET : CTRL_ECHO;
			end
		end else if (pick < 77) begin
			kind = KIND_BOX;
			if ($urandom_range(0, 4) != 0)
				din[7] = 1'b0;
		end else if (pick < 87) begin
			kind = KIND_CARD;
		end else if (pick < 97) begin
			kind = KIND_TXRDY;
		end else begin
			kind = 3'($urandom_range(5, 7));
		end
		send_item(kind, din);
	endtask

	task automatic test_directed();
		apply_settings(1, 2, 1, 3, 31, 7);
		send_item(KIND_HOST, DEST_CTRL);
		send_item(KIND_HOST, CTRL_ECHO);
		send_item(KIND_HOST, CTRL_RESET);
		send_item(KIND_HOST, 8'h02);
		send_item(KIND_TICK, 8'hFF);
		send_item(KIND_HOST, DEST_CARD);
		send_item(KIND_HOST, 8'hFF);
		send_item(KIND_CARD, 8'h00);
		send_item(KIND_CARD, 8'hFF);
		send_item(KIND_BOX, 8'h7F);
		send_item(KIND_BOX, BOX_DATA_LIMIT);
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_HOST, DEST_RING);
		send_item(KIND_HOST, 8'hAA);
		// box byte while the drive hold runs: dropped
		send_item(KIND_BOX, 8'h01);
		send_item(KIND_TXRDY, 8'h00);
		send_item(KIND_TXRDY, 8'hFF);
		repeat (2) send_item(KIND_TICK, 8'h00);
		send_item(KIND_HOST, DEST_LIGHT);
		send_item(KIND_HOST, 8'hFF);
		repeat (8) send_item(KIND_TICK, 8'h00);
		send_item(KIND_HOST, 8'h03);
		send_item(KIND_HOST, 8'h09);
		send_item(3'd5, 8'h00);
		send_item(3'd7, 8'hFF);
	endtask

	task automatic test_zero_registers();
		apply_settings(0, 0, 0, 0, 0, 0);
		send_item(KIND_HOST, DEST_RING);
		send_item(KIND_HOST, 8'h33);
		send_item(KIND_BOX, 8'h05);
		send_item(KIND_CARD, 8'h80);
		repeat (2) send_item(KIND_TICK, 8'h00);
		send_item(KIND_TXRDY, 8'h00);
	endtask

	// Overfill the ring behind a long result stall, then drain it past empty.
	task automatic test_ring_full();
		apply_settings(1, 1, 1, 511, 2, 2);
		while (sel_ticks != 0)
			send_item(KIND_TICK, 8'($urandom));
		send_item(KIND_HOST, DEST_RING);
		hold_req = 1'b1;
		repeat (RING_SIZE) send_item(KIND_HOST, 8'($urandom));
		repeat (RING_SIZE) send_item(KIND_TXRDY, 8'($urandom));
	endtask

	task automatic test_random_mix();
		apply_settings(3, 5, 2, 7, 3, 3);
		repeat (80) send_random_item();
		settle();
		repeat (70) send_random_item();
		apply_settings(12, 20, 6, 63, 7, 5);
		repeat (80) send_random_item();
		apply_settings(1, 1, 1, 1, 1, 1);
		quiet_mode = 1'b1;
		repeat (100) send_random_item();
		quiet_mode = 1'b0;
		apply_settings(4095, 4095, 4095, 511, 31, 7);
		repeat (90) send_random_item();
	endtask

	// Result sink: random stalls, plus one long hold on request.
	initial begin
		int stall_left;
		int gap;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				gap = (quiet_mode || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
				if (gap > 0) begin
					stall_left = gap - 1;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : check_beat
		route_beat_t got;
		route_beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.port, res_ch.byte_out, res_ch.light_on, res_ch.bus_drive, res_ch.last};
			beats_seen++;
			if (routed_beats.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected beat port=%0d byte=%02h", $realtime,
						got.port, got.byte_out);
				mismatches++;
			end else begin
				want = routed_beats.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display({"%0t: mismatch exp port=%0d byte=%02h light=%0b drive=%0b",
							" last=%0b, got port=%0d byte=%02h light=%0b drive=%0b last=%0b"},
							$realtime, want.port, want.byte_out, want.light_on,
							want.bus_drive, want.last, got.port, got.byte_out,
							got.light_on, got.bus_drive, got.last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.kind  <= KIND_TICK;
		item_ch.data  <= 8'h00;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= CFG_ROUTE_TIMEOUT;
		cfg_ch.wdata  <= '0;
		arst_n        <= 1'b0;
		cfg_route_to   = RST_ROUTE_TIMEOUT;
		cfg_hold_long  = RST_HOLD_LONG;
		cfg_hold_short = RST_HOLD_SHORT;
		cfg_pwm_top    = RST_PWM_TOP;
		cfg_ramp       = RST_RAMP_STEP;
		cfg_scale      = RST_LIGHT_SCALE;
		dest_sel   = '0;
		sel_ticks  = '0;
		src_ticks  = '0;
		hold_ticks = '0;
		drive_on   = 1'b0;
		rd_ptr     = 0;
		wr_ptr     = 0;
		pwm_cnt    = '0;
		duty_cur   = '0;
		duty_goal  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_zero_registers();
		test_ring_full();
		test_random_mix();

		settle();
		repeat (8) @(posedge clk);
		$display("Sent %0d items, checked %0d result beats over %0d register settings;",
			items_sent, beats_seen, settings_used);
		$display("ring overflow, a %0d-cycle result stall and zero registers included; %0d mismatches",
			LONG_HOLD, mismatches);
		if (mismatches == 0 && routed_beats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
